/* rtl/core/cdbm_pkg.sv */
// shared types, constants and divider table for the clock divider search
package cdbm_pkg;

    localparam int unsigned CLK_W      = 32;
    localparam int unsigned CODE_W     = 6;
    localparam int unsigned SCL_W      = 12;
    localparam int unsigned MULT_W     = 2;
    localparam int unsigned IDX_W      = 6;
    localparam int unsigned DIVISOR_W  = SCL_W + 2;
    localparam int unsigned BYTE_W     = MULT_W + CODE_W;
    localparam int unsigned STEP_W     = 5;

    localparam logic [CLK_W-1:0]  RATE_LIMIT_HZ = 32'd1000000;
    localparam logic [CLK_W-1:0]  NO_ERROR_YET  = 32'hffffffff;
    localparam logic [IDX_W-1:0]  LAST_IDX      = 6'd49;
    localparam logic [MULT_W-1:0] LAST_MULT     = 2'd2;
    localparam logic [STEP_W-1:0] LAST_STEP     = 5'd31;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [SCL_W-1:0]  divider;
    } scl_entry_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic eval;
        logic out_load;
    } cdbm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic reject;
        logic div_done;
        logic exact;
        logic last;
        logic out_busy;
    } cdbm_sts_t;

    function automatic scl_entry_t scl_rom(input logic [IDX_W-1:0] idx);
        scl_entry_t e;
        case (idx)
            6'd0:    e = '{6'h00, 12'd20};
            6'd1:    e = '{6'h01, 12'd22};
            6'd2:    e = '{6'h02, 12'd24};
            6'd3:    e = '{6'h03, 12'd26};
            6'd4:    e = '{6'h04, 12'd28};
            6'd5:    e = '{6'h05, 12'd30};
            6'd6:    e = '{6'h09, 12'd32};
            6'd7:    e = '{6'h06, 12'd34};
            6'd8:    e = '{6'h0a, 12'd36};
            6'd9:    e = '{6'h07, 12'd40};
            6'd10:   e = '{6'h0c, 12'd44};
            6'd11:   e = '{6'h10, 12'd48};
            6'd12:   e = '{6'h11, 12'd56};
            6'd13:   e = '{6'h12, 12'd64};
            6'd14:   e = '{6'h0f, 12'd68};
            6'd15:   e = '{6'h13, 12'd72};
            6'd16:   e = '{6'h14, 12'd80};
            6'd17:   e = '{6'h15, 12'd88};
            6'd18:   e = '{6'h19, 12'd96};
            6'd19:   e = '{6'h16, 12'd104};
            6'd20:   e = '{6'h1a, 12'd112};
            6'd21:   e = '{6'h17, 12'd128};
            6'd22:   e = '{6'h1c, 12'd144};
            6'd23:   e = '{6'h1d, 12'd160};
            6'd24:   e = '{6'h1e, 12'd192};
            6'd25:   e = '{6'h22, 12'd224};
            6'd26:   e = '{6'h1f, 12'd240};
            6'd27:   e = '{6'h23, 12'd256};
            6'd28:   e = '{6'h24, 12'd288};
            6'd29:   e = '{6'h25, 12'd320};
            6'd30:   e = '{6'h26, 12'd384};
            6'd31:   e = '{6'h2a, 12'd448};
            6'd32:   e = '{6'h27, 12'd480};
            6'd33:   e = '{6'h2b, 12'd512};
            6'd34:   e = '{6'h2c, 12'd576};
            6'd35:   e = '{6'h2d, 12'd640};
            6'd36:   e = '{6'h2e, 12'd768};
            6'd37:   e = '{6'h32, 12'd896};
            6'd38:   e = '{6'h2f, 12'd960};
            6'd39:   e = '{6'h33, 12'd1024};
            6'd40:   e = '{6'h34, 12'd1152};
            6'd41:   e = '{6'h35, 12'd1280};
            6'd42:   e = '{6'h36, 12'd1536};
            6'd43:   e = '{6'h3a, 12'd1792};
            6'd44:   e = '{6'h37, 12'd1920};
            6'd45:   e = '{6'h3b, 12'd2048};
            6'd46:   e = '{6'h3c, 12'd2304};
            6'd47:   e = '{6'h3d, 12'd2560};
            6'd48:   e = '{6'h3e, 12'd3072};
            6'd49:   e = '{6'h3f, 12'd3840};
            default: e = '{6'h00, 12'd20};
        endcase
        return e;
    endfunction

endpackage

/* rtl/core/cdbm_div.sv */
// serial restoring divider, one quotient bit per cycle
module cdbm_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [cdbm_pkg::CLK_W-1:0]          dividend,
    input  logic [cdbm_pkg::DIVISOR_W-1:0]      divisor,
    output logic                                busy,
    output logic                                done,
    output logic [cdbm_pkg::CLK_W-1:0]          quotient
);

    logic [cdbm_pkg::CLK_W-1:0]     quo_reg, quo_next;
    logic [cdbm_pkg::DIVISOR_W-1:0] rem_reg, rem_next;
    logic [cdbm_pkg::DIVISOR_W-1:0] dvs_reg;
    logic [cdbm_pkg::STEP_W-1:0]    step_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [cdbm_pkg::DIVISOR_W:0]   trial;
    logic [cdbm_pkg::DIVISOR_W:0]   diff;

    always_comb begin
        trial = {rem_reg, quo_reg[cdbm_pkg::CLK_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        // remainder stays below the divisor, so the low bits always fit
        if (trial >= {1'b0, dvs_reg}) begin
            rem_next = diff[cdbm_pkg::DIVISOR_W-1:0];
            quo_next = {quo_reg[cdbm_pkg::CLK_W-2:0], 1'b1};
        end else begin
            rem_next = trial[cdbm_pkg::DIVISOR_W-1:0];
            quo_next = {quo_reg[cdbm_pkg::CLK_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == cdbm_pkg::LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/core/cdbm_path.sv */
// datapath: request registers, candidate counters, best match tracking, output register
module cdbm_path (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cdbm_pkg::cdbm_cmd_t           cmd,
    output cdbm_pkg::cdbm_sts_t           sts,
    input  logic [2*cdbm_pkg::CLK_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cdbm_pkg::BYTE_W-1:0]   m_tdata,
    output logic                          m_tuser
);

    logic [cdbm_pkg::CLK_W-1:0]   clk_hz_reg;
    logic [cdbm_pkg::CLK_W-1:0]   target_reg;
    logic                         reject_reg;
    logic [cdbm_pkg::MULT_W-1:0]  mult_reg;
    logic [cdbm_pkg::IDX_W-1:0]   idx_reg;
    logic [cdbm_pkg::CLK_W-1:0]   best_err_reg, best_err_next;
    logic [cdbm_pkg::BYTE_W-1:0]  best_byte_reg;
    logic                         out_valid_reg;
    logic [cdbm_pkg::BYTE_W-1:0]  out_byte_reg;
    logic                         out_rej_reg;

    cdbm_pkg::scl_entry_t         entry;
    logic [cdbm_pkg::DIVISOR_W-1:0] divisor;
    logic [cdbm_pkg::CLK_W-1:0]   rate;
    logic [cdbm_pkg::CLK_W-1:0]   err;
    logic                         better;
    logic                         div_busy;
    logic                         div_done;

    always_comb begin
        entry   = cdbm_pkg::scl_rom(idx_reg);
        divisor = {2'b00, entry.divider} << mult_reg;
    end

    cdbm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (clk_hz_reg),
        .divisor  (divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (rate)
    );

    always_comb begin
        err           = (target_reg > rate) ? (target_reg - rate) : (rate - target_reg);
        better        = err < best_err_reg;
        best_err_next = better ? err : best_err_reg;
    end

    always_comb begin
        sts.reject   = reject_reg;
        sts.div_done = div_done;
        sts.exact    = (best_err_next == '0);
        sts.last     = (mult_reg == cdbm_pkg::LAST_MULT) && (idx_reg == cdbm_pkg::LAST_IDX);
        sts.out_busy = out_valid_reg && !m_tready;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            clk_hz_reg    <= s_tdata[cdbm_pkg::CLK_W-1:0];
            target_reg    <= s_tdata[2*cdbm_pkg::CLK_W-1:cdbm_pkg::CLK_W];
            reject_reg    <= s_tdata[2*cdbm_pkg::CLK_W-1:cdbm_pkg::CLK_W]
                             > cdbm_pkg::RATE_LIMIT_HZ;
            mult_reg      <= '0;
            idx_reg       <= '0;
            best_err_reg  <= cdbm_pkg::NO_ERROR_YET;
            best_byte_reg <= '0;
        end else if (cmd.eval) begin
            best_err_reg <= best_err_next;
            if (better) begin
                best_byte_reg <= {mult_reg, entry.code};
            end
            if (idx_reg == cdbm_pkg::LAST_IDX) begin
                idx_reg  <= '0;
                mult_reg <= mult_reg + 1'b1;
            end else begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_byte_reg <= reject_reg ? '0 : best_byte_reg;
            out_rej_reg  <= reject_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_rej_reg;

`ifndef SYNTHESIS
    a_load_init: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (mult_reg == '0) && (idx_reg == '0)
                     && (best_err_reg == cdbm_pkg::NO_ERROR_YET))
        else $error("search state not initialized on load");

    a_err_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.eval |=> best_err_reg <= $past(best_err_reg))
        else $error("best error grew during search");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(out_valid_reg && !m_tready))
        else $error("result overwritten before it was taken");

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !div_busy)
        else $error("divider started while busy");

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_rej_reg) |-> (out_byte_reg == '0))
        else $error("rejected result carries a divider byte");
`endif

endmodule

/* rtl/core/cdbm_ctrl.sv */
// control state machine sequencing the candidate search
module cdbm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  cdbm_pkg::cdbm_sts_t  sts,
    output cdbm_pkg::cdbm_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_EVAL,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_tready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.reject) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (sts.div_done) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
                // an exact hit cannot be beaten, stop early
                if (sts.exact || sts.last) begin
                    state_next = ST_FINISH;
                end else begin
                    // table index steps on this edge, the next divide starts from check
                    state_next = ST_CHECK;
                end
            end
            ST_FINISH: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/clock_divider_best_match_search.sv */
// top level of the clock divider best match search
// Each request carries a source clock and a target bus rate and yields one result: the
// divider byte (multiplier index in bits 7:6, rate code in bits 5:0) whose rate
// source / (multiplier * divider) lies closest to the target, or a rejected flag with a
// zero byte when the target exceeds 1000000. Up to 150 candidates are tried in order
// (multipliers 1, 2, 4 over the 50-entry table), each through a divider start in the check
// state, the serial divider that yields one quotient bit per cycle and the evaluation state;
// the search stops early on an exact match and a rejected request goes from the check state
// straight to finish. One request is in work at a time; a new one is taken while the
// previous result still waits in the output register.
module clock_divider_best_match_search (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [2*cdbm_pkg::CLK_W-1:0]        s_tdata,  // source_clock_hz, target_rate_hz
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [cdbm_pkg::BYTE_W-1:0]         m_tdata,  // divider_byte
    output logic                                m_tuser   // rejected
);

    cdbm_pkg::cdbm_cmd_t cmd;
    cdbm_pkg::cdbm_sts_t sts;

    cdbm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cdbm_path u_path (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* tb/tb_top.sv */
// self-checking testbench for the clock divider best match search
module tb_top;

    localparam int unsigned N_RANDOM  = 100;
    localparam int unsigned CALM_TAIL = 30;
    localparam int unsigned MAX_SHOWN = 10;

    typedef logic [cdbm_pkg::CLK_W-1:0]  hz_t;
    typedef logic [cdbm_pkg::MULT_W-1:0] mult_t;

    typedef struct {
        logic [cdbm_pkg::BYTE_W-1:0] div_byte;
        logic                        rejected;
    } divider_result_t;

    // holds the divider table, predicts each request and matches results in order
    class divider_scoreboard;
        logic [cdbm_pkg::CODE_W-1:0] rate_code [50];
        logic [cdbm_pkg::SCL_W-1:0]  scl_div [50];
        divider_result_t             pending_q [$];
        int unsigned                 errors;

        function new();
            rate_code = '{6'h00, 6'h01, 6'h02, 6'h03, 6'h04, 6'h05, 6'h09, 6'h06, 6'h0a, 6'h07,
                          6'h0c, 6'h10, 6'h11, 6'h12, 6'h0f, 6'h13, 6'h14, 6'h15, 6'h19, 6'h16,
                          6'h1a, 6'h17, 6'h1c, 6'h1d, 6'h1e, 6'h22, 6'h1f, 6'h23, 6'h24, 6'h25,
                          6'h26, 6'h2a, 6'h27, 6'h2b, 6'h2c, 6'h2d, 6'h2e, 6'h32, 6'h2f, 6'h33,
                          6'h34, 6'h35, 6'h36, 6'h3a, 6'h37, 6'h3b, 6'h3c, 6'h3d, 6'h3e, 6'h3f};
            scl_div = '{12'd20, 12'd22, 12'd24, 12'd26, 12'd28, 12'd30, 12'd32, 12'd34,
                        12'd36, 12'd40, 12'd44, 12'd48, 12'd56, 12'd64, 12'd68, 12'd72,
                        12'd80, 12'd88, 12'd96, 12'd104, 12'd112, 12'd128, 12'd144,
                        12'd160, 12'd192, 12'd224, 12'd240, 12'd256, 12'd288, 12'd320,
                        12'd384, 12'd448, 12'd480, 12'd512, 12'd576, 12'd640, 12'd768,
                        12'd896, 12'd960, 12'd1024, 12'd1152, 12'd1280, 12'd1536,
                        12'd1792, 12'd1920, 12'd2048, 12'd2304, 12'd2560, 12'd3072,
                        12'd3840};
            errors = 0;
        endfunction

        // first candidate with the strictly smallest error, stop once an exact hit is held
        function logic [cdbm_pkg::BYTE_W-1:0] best_divider(hz_t clk_hz, hz_t target_hz);
            hz_t                         best_err;
            hz_t                         divisor;
            hz_t                         rate;
            hz_t                         err;
            mult_t                       win_mult;
            logic [cdbm_pkg::CODE_W-1:0] best_code;
            best_err  = cdbm_pkg::NO_ERROR_YET;
            win_mult  = '0;
            best_code = '0;
            for (int m = 0; m <= 2; m++) begin
                for (int k = 0; k < 50; k++) begin
                    if (best_err != 0) begin
                        divisor = hz_t'(scl_div[k]) << m;
                        rate    = clk_hz / divisor;
                        err     = (target_hz > rate) ? target_hz - rate : rate - target_hz;
                        if (err < best_err) begin
                            best_err  = err;
                            win_mult  = mult_t'(m);
                            best_code = rate_code[k];
                        end
                    end
                end
            end
            return {win_mult, best_code};
        endfunction

        function void note_request(hz_t clk_hz, hz_t target_hz);
            divider_result_t exp_res;
            if (target_hz > cdbm_pkg::RATE_LIMIT_HZ) begin
                exp_res.div_byte = '0;
                exp_res.rejected = 1'b1;
            end else begin
                exp_res.div_byte = best_divider(clk_hz, target_hz);
                exp_res.rejected = 1'b0;
            end
            pending_q.push_back(exp_res);
        endfunction

        function void check_result(logic [cdbm_pkg::BYTE_W-1:0] got_byte, logic got_rejected);
            divider_result_t exp_res;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("unexpected result: byte %02h rejected %0b", got_byte, got_rejected);
                return;
            end
            exp_res = pending_q.pop_front();
            if (got_byte !== exp_res.div_byte || got_rejected !== exp_res.rejected) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("bad result: expected byte %02h rejected %0b, %s %02h %s %0b",
                             exp_res.div_byte, exp_res.rejected, "got byte", got_byte,
                             "rejected", got_rejected);
            end
        endfunction

        function int unsigned outstanding();
            return pending_q.size();
        endfunction
    endclass

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [2*cdbm_pkg::CLK_W-1:0]    s_tdata = '0;   // source_clock_hz, target_rate_hz
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [cdbm_pkg::BYTE_W-1:0]     m_tdata;        // divider_byte
    logic                            m_tuser;        // rejected

    logic                            calm = 1'b0;
    int unsigned                     ready_hold = 0;

    divider_scoreboard sb = new();

    clock_divider_best_match_search u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 aclk = ~aclk;

    // result side back-pressure in bursts
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_tready   = 1'b0;
            ready_hold = ready_hold - 1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            m_tready   = 1'b0;
            ready_hold = $urandom_range(1, 15) - 1;
        end else begin
            m_tready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    // called at a falling edge, returns at the falling edge after the request is taken
    task automatic send_request(hz_t clk_hz, hz_t target_hz);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {target_hz, clk_hz};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(clk_hz, target_hz);
        @(negedge aclk);
    endtask

    task automatic random_request();
        hz_t         clk_hz;
        hz_t         target_hz;
        hz_t         divisor;
        hz_t         q_max;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            // over the rate limit
            clk_hz    = $urandom;
            target_hz = $urandom_range(32'hffffffff, cdbm_pkg::RATE_LIMIT_HZ + 1);
        end else if (pick < 5) begin
            // clock built so that some candidate hits the target exactly
            divisor   = hz_t'(sb.scl_div[$urandom_range(0, 49)]) << $urandom_range(0, 2);
            q_max     = 32'hffffffff / divisor - 1;
            if (q_max > cdbm_pkg::RATE_LIMIT_HZ)
                q_max = cdbm_pkg::RATE_LIMIT_HZ;
            target_hz = $urandom_range(1, q_max);
            clk_hz    = target_hz * divisor;
            if ($urandom_range(0, 1) == 1)
                clk_hz = clk_hz + $urandom_range(0, divisor - 1);
        end else if (pick < 8) begin
            clk_hz    = $urandom_range(200_000_000, 1_000_000);
            target_hz = $urandom_range(cdbm_pkg::RATE_LIMIT_HZ, 0);
        end else if (pick < 9) begin
            clk_hz    = $urandom;
            target_hz = $urandom_range(cdbm_pkg::RATE_LIMIT_HZ, 0);
        end else begin
            // slow clocks where many rates collapse to zero
            clk_hz    = $urandom_range(5000, 0);
            target_hz = $urandom_range(50, 0);
        end
        send_request(clk_hz, target_hz);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed corners
        send_request(32'd0, 32'd0);
        send_request(32'd0, cdbm_pkg::RATE_LIMIT_HZ);
        send_request(32'd19, 32'd5);
        send_request(32'hffffffff, 32'd0);
        send_request(32'hffffffff, cdbm_pkg::RATE_LIMIT_HZ);
        send_request(32'hffffffff, cdbm_pkg::RATE_LIMIT_HZ + 1);
        send_request(32'h5a5a5a5a, 32'hffffffff);
        send_request(32'd0, 32'h80000000);
        send_request(32'd50_000_000, 32'd0);
        send_request(32'd50_000_000, 32'd1);
        send_request(32'd48_000_000, 32'd100_000);
        send_request(32'd768_000, 32'd100);
        send_request(32'd1_536_000, 32'd100);
        send_request(32'd1_536_000 + 32'd15_359, 32'd100);
        send_request(32'd20_000_000, cdbm_pkg::RATE_LIMIT_HZ);
        send_request(32'd100_000_000, 32'd400_000);
        send_request(32'd24_000_000, 32'd333_333);
        send_request(32'd20, 32'd1);
        send_request(32'd3839, 32'd0);
        send_request(32'haaaaaaaa, 32'h000aaaaa);
        send_request(32'h55555555, 32'h00055555);

        // hold off until the block has returned everything
        s_tvalid = 1'b0;
        while (sb.outstanding() != 0) @(negedge aclk);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM - CALM_TAIL)
                calm = 1'b1;
            random_request();
        end
        s_tvalid = 1'b0;

        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
